/* rtl/smct_pkg.sv */
// ---------------------------------------------------------------------------
// smct_pkg
// shared types and codes for the sparse matrix coordinate table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smct_pkg;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed
    {
        logic [1:0]         command;
        logic [15:0]        row_index;
        logic [15:0]        column_index;
        logic signed [31:0] entry_value;
    } request_t;

    typedef struct packed
    {
        logic signed [31:0] read_value;
        logic               found;
        logic               full_error;
        logic [6:0]         entry_count;
    } response_t;

    // per-cell control
    typedef struct packed
    {
        logic compare;
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/smct_cell.sv */
// ---------------------------------------------------------------------------
// smct_cell
// one table slot: holds an entry, compares it to the key, shifts or loads
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smct_cell #(
    parameter int COORD_BITS = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire                          clk,
    input  wire  smct_pkg::cell_ctrl_t   ctrl,
    input  wire                          occupied,
    input  wire        [COORD_BITS-1:0]  key_row,
    input  wire        [COORD_BITS-1:0]  key_col,
    input  wire        [COORD_BITS-1:0]  new_row,
    input  wire        [COORD_BITS-1:0]  new_col,
    input  wire        [VALUE_BITS-1:0]  new_value,
    input  wire        [COORD_BITS-1:0]  next_row,
    input  wire        [COORD_BITS-1:0]  next_col,
    input  wire        [VALUE_BITS-1:0]  next_value,
    output logic       [COORD_BITS-1:0]  row,
    output logic       [COORD_BITS-1:0]  col,
    output logic       [VALUE_BITS-1:0]  value,
    output logic                         match
);

    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  match_reg, match_next;

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        value_next = value_reg;
        if (ctrl.load)
        begin
            row_next   = new_row;
            col_next   = new_col;
            value_next = new_value;
        end
        else if (ctrl.shift)
        begin
            // take the younger neighbor's entry
            row_next   = next_row;
            col_next   = next_col;
            value_next = next_value;
        end
        match_next = match_reg;
        if (ctrl.compare)
        begin
            match_next = occupied && (row_reg == key_row) && (col_reg == key_col);
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        value_reg <= value_next;
        match_reg <= match_next;
    end

    assign row   = row_reg;
    assign col   = col_reg;
    assign value = value_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

/* rtl/smct_prefix.sv */
// ---------------------------------------------------------------------------
// smct_prefix
// log-depth inclusive prefix or over the cell match flags
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smct_prefix #(
    parameter int WIDTH = 64
) (
    input  wire  [WIDTH-1:0] bits,
    output logic [WIDTH-1:0] prefix
);

    localparam int LEVELS = $clog2(WIDTH);

    logic [LEVELS:0][WIDTH-1:0] stage;

    assign stage[0] = bits;

    for (genvar lvl = 0; lvl < LEVELS; lvl++)
    begin : g_level
        for (genvar j = 0; j < WIDTH; j++)
        begin : g_bit
            if (j >= (1 << lvl))
            begin : g_merge
                assign stage[lvl+1][j] = stage[lvl][j] | stage[lvl][j-(1<<lvl)];
            end
            else
            begin : g_pass
                assign stage[lvl+1][j] = stage[lvl][j];
            end
        end
    end

    assign prefix = stage[LEVELS];

endmodule

`default_nettype wire

/* rtl/sparse_matrix_coordinate_table.sv */
// ---------------------------------------------------------------------------
// sparse_matrix_coordinate_table
// coordinate-list store for a sparse matrix, built as a row of table cells
// ---------------------------------------------------------------------------
// Each word is handled in two steps: in the cycle it is accepted every cell
// compares its (row, column) against the key at once; then, in the exec state
// and once the output register is free or being emptied, a prefix-or over the
// match flags picks the oldest match, and the cells either shift down by one
// (delete), load the new entry at the tail (insert) or hand the selected value
// to the output (lookup). The result then sits in an output register, so the
// next word is accepted while a response waits to be taken. A new word is not
// accepted until the last one has updated the cell row, after its compare.
// Entries are kept in insertion order, cell 0 oldest. Cells at or beyond the
// entry count never match, so unwritten cells are never read and need no
// clearing after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sparse_matrix_coordinate_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int COORD_BITS  = 16,
    parameter int VALUE_BITS  = 32
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   request_valid,
    output logic                  request_ready,
    input  wire smct_pkg::request_t request,
    output logic                  response_valid,
    input  wire                   response_ready,
    output smct_pkg::response_t   response
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // control state
    smct_pkg::state_t     state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 resp_valid_reg, resp_valid_next;

    // latched word for the update cycle
    logic [1:0]            cmd_reg;
    logic [COORD_BITS-1:0] row_reg;
    logic [COORD_BITS-1:0] col_reg;
    logic [VALUE_BITS-1:0] value_reg;

    smct_pkg::response_t  resp_reg, resp_next;

    // cell row
    logic [COORD_BITS-1:0] cell_row   [TABLE_DEPTH];
    logic [COORD_BITS-1:0] cell_col   [TABLE_DEPTH];
    logic [VALUE_BITS-1:0] cell_value [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] prefix_vec;
    logic [TABLE_DEPTH-1:0] first_vec;
    smct_pkg::cell_ctrl_t  cell_ctrl [TABLE_DEPTH];

    logic                         accept;
    logic                         fire;
    logic                         any_match;
    logic                         table_full;
    logic signed [VALUE_BITS-1:0] sel_value;
    logic [COORD_BITS-1:0]        key_row;
    logic [COORD_BITS-1:0]        key_col;

    assign request_ready  = (state_reg == smct_pkg::ST_IDLE);
    assign accept         = request_valid && request_ready;
    // update only when the output register is free or being emptied
    assign fire           = (state_reg == smct_pkg::ST_EXEC)
                            && (!resp_valid_reg || response_ready);
    assign key_row        = COORD_BITS'(request.row_index);
    assign key_col        = COORD_BITS'(request.column_index);
    assign table_full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign any_match      = prefix_vec[TABLE_DEPTH-1];
    // oldest match: a match with no match below it
    assign first_vec      = match_vec & ~(prefix_vec << 1);

    // the cells
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [COORD_BITS-1:0] nb_row;
        logic [COORD_BITS-1:0] nb_col;
        logic [VALUE_BITS-1:0] nb_value;

        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign nb_row   = '0;
            assign nb_col   = '0;
            assign nb_value = '0;
        end
        else
        begin : g_link
            assign nb_row   = cell_row[i+1];
            assign nb_col   = cell_col[i+1];
            assign nb_value = cell_value[i+1];
        end

        always_comb
        begin
            cell_ctrl[i].compare = accept;
            // every cell at or above the oldest match moves down one
            cell_ctrl[i].shift   = fire && (cmd_reg == smct_pkg::CMD_DELETE)
                                   && prefix_vec[i];
            cell_ctrl[i].load    = fire && (cmd_reg == smct_pkg::CMD_INSERT)
                                   && (count_reg == CNT_W'(i));
        end

        smct_cell #(
            .COORD_BITS (COORD_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .occupied   (count_reg > CNT_W'(i)),
            .key_row    (key_row),
            .key_col    (key_col),
            .new_row    (row_reg),
            .new_col    (col_reg),
            .new_value  (value_reg),
            .next_row   (nb_row),
            .next_col   (nb_col),
            .next_value (nb_value),
            .row        (cell_row[i]),
            .col        (cell_col[i]),
            .value      (cell_value[i]),
            .match      (match_vec[i])
        );
    end

    smct_prefix #(
        .WIDTH (TABLE_DEPTH)
    ) u_prefix (
        .bits   (match_vec),
        .prefix (prefix_vec)
    );

    // value of the oldest match, or-ed over the one-hot select
    always_comb
    begin
        sel_value = '0;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            sel_value = sel_value | (cell_value[j] & {VALUE_BITS{first_vec[j]}});
        end
    end

    // next state and response
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        resp_next       = resp_reg;
        resp_valid_next = resp_valid_reg && !response_ready;

        case (state_reg)
            smct_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = smct_pkg::ST_EXEC;
                end
            end
            smct_pkg::ST_EXEC:
            begin
                if (fire)
                begin
                    resp_next.read_value = '0;
                    resp_next.found      = 1'b0;
                    resp_next.full_error = 1'b0;
                    case (cmd_reg)
                        smct_pkg::CMD_INSERT:
                        begin
                            if (table_full)
                            begin
                                resp_next.full_error = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        smct_pkg::CMD_DELETE:
                        begin
                            if (any_match)
                            begin
                                count_next      = count_reg - CNT_W'(1);
                                resp_next.found = 1'b1;
                            end
                        end
                        smct_pkg::CMD_LOOKUP:
                        begin
                            if (any_match)
                            begin
                                resp_next.read_value = 32'(sel_value);
                                resp_next.found      = 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused command: no change
                        end
                    endcase
                    resp_next.entry_count = 7'(count_next);
                    resp_valid_next       = 1'b1;
                    state_next            = smct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = smct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= smct_pkg::ST_IDLE;
            count_reg      <= '0;
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            resp_valid_reg <= resp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= request.command;
            row_reg   <= key_row;
            col_reg   <= key_col;
            value_reg <= VALUE_BITS'(request.entry_value);
        end
        resp_reg <= resp_next;
    end

    assign response_valid = resp_valid_reg;
    assign response       = resp_reg;

`ifndef ASSERT_OFF
    // entry count stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // priority select never picks two cells once the flags are compared
    a_first_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == smct_pkg::ST_EXEC) |-> $onehot0(first_vec))
        else $error("more than one oldest match");

    // an accepted word is always followed by the exec state, where it waits to update
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == smct_pkg::ST_EXEC))
        else $error("accepted word not executed");

    // a response never reports a match and a full table together
    a_resp_flags: assert property (@(posedge clk) disable iff (!rst_n)
        response_valid |-> !(response.found && response.full_error))
        else $error("found and full_error both set");
`endif

endmodule

`default_nettype wire
